// ===== src/gbbi_pkg.sv =====
package gbbi_pkg;

  localparam int GRID_COLS_DEF   = 256;
  localparam int GRID_ROWS_DEF   = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ELEV_W = 27;
  localparam int LON_W  = 33;
  localparam int LAT_W  = 32;
  localparam int STEP_W = 32;
  localparam int USED_W = 9;
  localparam int FRAC_W = 16;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [1:0] MODE_WRITE    = 2'd0;
  localparam logic [1:0] MODE_BILINEAR = 2'd1;
  localparam logic [1:0] MODE_BICUBIC  = 2'd2;

  localparam logic [1:0] MSTEP_NONE   = 2'd0;
  localparam logic [1:0] MSTEP_FIRST  = 2'd1;
  localparam logic [1:0] MSTEP_SECOND = 2'd2;
  localparam logic [1:0] MSTEP_THIRD  = 2'd3;

  typedef struct packed {
    logic [LON_W-1:0]  origin_lon;
    logic [LAT_W-1:0]  origin_lat;
    logic [STEP_W-1:0] cols_per_degree;
    logic [STEP_W-1:0] rows_per_degree;
    logic [USED_W-1:0] width_used;
    logic [USED_W-1:0] height_used;
  } cfg_t;

  typedef struct packed {
    logic       wr;
    logic       capture;
    logic       pos_mul;
    logic       pos_sum;
    logic       pos_clamp;
    logic       rd_issue;
    logic [1:0] rd_row;
    logic [1:0] rd_col;
    logic       rr_load;
    logic [1:0] mul_step;
    logic       cubic;
    logic       vert;
    logic       fin;
    logic       round;
    logic       out_load;
  } dp_cmd_t;

endpackage

// ===== src/gbbi_regs.sv =====
module gbbi_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbbi_pkg::ADDR_W-1:0]  paddr,
  input  logic [gbbi_pkg::DATA_W-1:0]  pwdata,
  output logic [gbbi_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output gbbi_pkg::cfg_t               cfg
);
  import gbbi_pkg::*;

  localparam logic [2:0] REG_ORIGIN_LON  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_LAT  = 3'd1;
  localparam logic [2:0] REG_COLS_PER_DEG = 3'd2;
  localparam logic [2:0] REG_ROWS_PER_DEG = 3'd3;
  localparam logic [2:0] REG_WIDTH_USED  = 3'd4;
  localparam logic [2:0] REG_HEIGHT_USED = 3'd5;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_lon      <= '0;
      cfg.origin_lat      <= '0;
      cfg.cols_per_degree <= STEP_W'(235929600);
      cfg.rows_per_degree <= STEP_W'(235929600);
      cfg.width_used      <= USED_W'(256);
      cfg.height_used     <= USED_W'(256);
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_LON:   cfg.origin_lon      <= pwdata[LON_W-1:0];
        REG_ORIGIN_LAT:   cfg.origin_lat      <= pwdata[LAT_W-1:0];
        REG_COLS_PER_DEG: cfg.cols_per_degree <= pwdata[STEP_W-1:0];
        REG_ROWS_PER_DEG: cfg.rows_per_degree <= pwdata[STEP_W-1:0];
        REG_WIDTH_USED:   cfg.width_used      <= pwdata[USED_W-1:0];
        REG_HEIGHT_USED:  cfg.height_used     <= pwdata[USED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (idx)
        REG_ORIGIN_LON:   prdata = DATA_W'(cfg.origin_lon);
        REG_ORIGIN_LAT:   prdata = DATA_W'(cfg.origin_lat);
        REG_COLS_PER_DEG: prdata = DATA_W'(cfg.cols_per_degree);
        REG_ROWS_PER_DEG: prdata = DATA_W'(cfg.rows_per_degree);
        REG_WIDTH_USED:   prdata = DATA_W'(cfg.width_used);
        REG_HEIGHT_USED:  prdata = DATA_W'(cfg.height_used);
        default:          prdata = '0;
      endcase
    end
  end

endmodule

// ===== src/gbbi_ctrl.sv =====
module gbbi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        mode,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gbbi_pkg::dp_cmd_t cmd
);
  import gbbi_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_POS_MUL   = 11'b00000000010,
    S_POS_SUM   = 11'b00000000100,
    S_POS_CLAMP = 11'b00000001000,
    S_READ      = 11'b00000010000,
    S_WAIT      = 11'b00000100000,
    S_MUL       = 11'b00001000000,
    S_FIN       = 11'b00010000000,
    S_VLOAD     = 11'b00100000000,
    S_ROUND     = 11'b01000000000,
    S_DONE      = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] col, col_next;
  logic [1:0] row, row_next;
  logic [1:0] step, step_next;
  logic       vert, vert_next;
  logic       cubic, cubic_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    step_next      = step;
    vert_next      = vert;
    cubic_next     = cubic;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.cubic      = cubic;
    cmd.vert       = vert;
    cmd.rd_row     = row;
    cmd.rd_col     = col;
    case (state)
      S_IDLE: begin
        cmd.wr      = in_valid && (mode == MODE_WRITE);
        cmd.capture = in_valid && (mode == MODE_BILINEAR || mode == MODE_BICUBIC);
        if (cmd.capture) begin
          cubic_next = (mode == MODE_BICUBIC);
          state_next = S_POS_MUL;
        end
      end
      S_POS_MUL: begin
        cmd.pos_mul = 1'b1;
        state_next  = S_POS_SUM;
      end
      S_POS_SUM: begin
        cmd.pos_sum = 1'b1;
        state_next  = S_POS_CLAMP;
      end
      S_POS_CLAMP: begin
        cmd.pos_clamp = 1'b1;
        col_next      = 2'd0;
        row_next      = 2'd0;
        vert_next     = 1'b0;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        col_next     = col + 2'd1;
        if (col == 2'd3) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        step_next  = MSTEP_FIRST;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = step;
        if (!cubic || step == MSTEP_THIRD) begin
          state_next = S_FIN;
        end else begin
          step_next = step + 2'd1;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (vert) begin
          state_next = S_ROUND;
        end else if (row == 2'd3) begin
          vert_next  = 1'b1;
          state_next = S_VLOAD;
        end else begin
          row_next   = row + 2'd1;
          state_next = S_READ;
        end
      end
      S_VLOAD: begin
        cmd.rr_load = 1'b1;
        step_next   = MSTEP_FIRST;
        state_next  = S_MUL;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= 2'd0;
      row       <= 2'd0;
      step      <= MSTEP_NONE;
      vert      <= 1'b0;
      cubic     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      step      <= step_next;
      vert      <= vert_next;
      cubic     <= cubic_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/gbbi_dpath.sv =====
module gbbi_dpath #(
  parameter int GRID_COLS   = gbbi_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = gbbi_pkg::GRID_ROWS_DEF,
  parameter int SAMPLE_BITS = gbbi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gbbi_pkg::dp_cmd_t                 cmd,
  input  gbbi_pkg::cfg_t                    cfg,
  input  logic [7:0]                        write_col,
  input  logic [7:0]                        write_row,
  input  logic signed [15:0]                write_value,
  input  logic signed [gbbi_pkg::LAT_W-1:0] query_lat,
  input  logic signed [gbbi_pkg::LON_W-1:0] query_lon,
  output logic signed [gbbi_pkg::ELEV_W-1:0] elevation
);
  import gbbi_pkg::*;

  localparam int CB = $clog2(GRID_COLS);
  localparam int RB = $clog2(GRID_ROWS);
  localparam int AW = CB + RB;
  localparam int VW = SAMPLE_BITS + 24;
  localparam int PW = VW + 17;
  localparam int IW = 28;
  localparam int PXW = 42;

  localparam logic signed [PW-1:0] HALF16 = PW'(1) <<< 15;
  localparam logic signed [PW-1:0] HALF17 = PW'(1) <<< 16;
  localparam logic signed [VW-1:0] HALF8  = VW'(128);

  function automatic logic [IW-1:0] clampi(input logic signed [IW-1:0] v,
                                           input logic signed [IW-1:0] last);
    if (v < 0) return '0;
    if (v > last) return last;
    return v;
  endfunction

  logic signed [SAMPLE_BITS-1:0] mem [0:(1<<AW)-1];
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic [AW-1:0]                 mem_addr;
  logic                          mem_we;
  logic                          rd_valid;

  logic signed [LON_W:0]   dx;
  logic signed [LAT_W:0]   dy;
  logic [LON_W-1:0]        mag_x, mag_y;
  logic [40:0]             hx, hy;
  logic [55:0]             lx, ly;
  logic [PXW-1:0]          px, py;
  logic [FRAC_W-1:0]       tx, ty;
  logic [CB-1:0]           col_idx [4];
  logic [RB-1:0]           row_idx [4];
  logic signed [IW-1:0]    lim_c, lim_r;

  logic signed [VW-1:0]    win [4];
  logic signed [VW-1:0]    rr [4];
  logic signed [PW-1:0]    prod;
  logic signed [16:0]      t17;
  logic signed [VW-1:0]    r16, r17, diff_bc, coef_a, coef_b, coef_c, op, fval;
  logic signed [VW-1:0]    fin_val, q;
  logic signed [ELEV_W-1:0] res_q;

  // grid memory, single port
  assign mem_we   = cmd.wr && (int'(write_col) < GRID_COLS) && (int'(write_row) < GRID_ROWS);
  assign mem_addr = cmd.wr ? {RB'(write_row), CB'(write_col)}
                           : {row_idx[cmd.rd_row], col_idx[cmd.rd_col]};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= SAMPLE_BITS'(write_value);
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_valid <= 1'b0;
    else     rd_valid <= cmd.rd_issue;
  end

  // pixel position
  assign mag_x = (dx > 0) ? dx[LON_W-1:0] : '0;
  assign mag_y = (dy > 0) ? {1'b0, dy[LAT_W-1:0]} : '0;

  always_comb begin
    lim_c = (cfg.width_used == '0) ? IW'(1) : IW'(cfg.width_used);
    if (lim_c > IW'(GRID_COLS)) lim_c = IW'(GRID_COLS);
    lim_r = (cfg.height_used == '0) ? IW'(1) : IW'(cfg.height_used);
    if (lim_r > IW'(GRID_ROWS)) lim_r = IW'(GRID_ROWS);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx <= $signed({query_lon[LON_W-1], query_lon})
          - $signed({cfg.origin_lon[LON_W-1], cfg.origin_lon});
      dy <= $signed({cfg.origin_lat[LAT_W-1], cfg.origin_lat})
          - $signed({query_lat[LAT_W-1], query_lat});
    end
    if (cmd.pos_mul) begin
      hx <= 41'(mag_x[32:24]) * 41'(cfg.cols_per_degree);
      lx <= 56'(mag_x[23:0]) * 56'(cfg.cols_per_degree);
      hy <= 41'(mag_y[32:24]) * 41'(cfg.rows_per_degree);
      ly <= 56'(mag_y[23:0]) * 56'(cfg.rows_per_degree);
    end
    if (cmd.pos_sum) begin
      px <= PXW'(hx) + PXW'(lx[55:24]);
      py <= PXW'(hy) + PXW'(ly[55:24]);
    end
    if (cmd.pos_clamp) begin
      tx <= px[FRAC_W-1:0];
      ty <= py[FRAC_W-1:0];
      for (int i = 0; i < 4; i++) begin
        col_idx[i] <= CB'(clampi($signed({2'b00, px[PXW-1:FRAC_W]}) + IW'(i - 1),
                                 lim_c - IW'(1)));
        row_idx[i] <= RB'(clampi($signed({2'b00, py[PXW-1:FRAC_W]}) + IW'(i - 1),
                                 lim_r - IW'(1)));
      end
    end
  end

  // interpolation: shared multiplier, three steps per Catmull-Rom, one per lerp
  assign t17     = $signed({1'b0, (cmd.vert ? ty : tx)});
  assign r16     = VW'((prod + HALF16) >>> 16);
  assign r17     = VW'((prod + HALF17) >>> 17);
  assign diff_bc = win[1] - win[2];
  assign coef_a  = (diff_bc <<< 1) + diff_bc + win[3] - win[0];
  assign coef_b  = (win[0] <<< 1) - ((win[1] <<< 2) + win[1]) + (win[2] <<< 2) - win[3];
  assign coef_c  = win[2] - win[0];
  assign fval    = cmd.cubic ? win[1] + r17 : win[1] + r16;

  always_comb begin
    case (cmd.mul_step)
      MSTEP_FIRST:  op = cmd.cubic ? coef_a : win[2] - win[1];
      MSTEP_SECOND: op = r16 + coef_b;
      MSTEP_THIRD:  op = r16 + coef_c;
      default:      op = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= VW'(rdata) <<< 16;
    end else if (cmd.rr_load) begin
      win <= rr;
    end
    if (cmd.mul_step != MSTEP_NONE) prod <= op * t17;
    if (cmd.fin) begin
      if (cmd.vert) begin
        fin_val <= fval;
      end else begin
        rr[0] <= rr[1];
        rr[1] <= rr[2];
        rr[2] <= rr[3];
        rr[3] <= fval;
      end
    end
  end

  // round to Q8 and saturate
  assign q = (fin_val + HALF8) >>> 8;

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      if (q[VW-1:ELEV_W-1] == '0 || q[VW-1:ELEV_W-1] == '1)
        res_q <= q[ELEV_W-1:0];
      else if (q[VW-1])
        res_q <= {1'b1, {(ELEV_W-1){1'b0}}};
      else
        res_q <= {1'b0, {(ELEV_W-1){1'b1}}};
    end
    if (cmd.out_load) elevation <= res_q;
  end

endmodule

// ===== src/grid_bilinear_bicubic_interpolator_core.sv =====
// channel  handshake                  payload
// in       in_valid / in_stall        mode, write_col, write_row, write_value,
//                                     query_lat, query_lon
// out      out_valid / out_stall      elevation
// cfg      psel/penable/pwrite/pready paddr, pwdata, prdata (64-bit, 8*index)
//
// A write beat is accepted in idle and leaves the block idle. The time from
// accept to result of a bilinear or bicubic query is set by the single-port grid
// memory (one sample read per cycle) and the one shared multiplier.
// Reset is synchronous and clears control state; the grid is not cleared.
// A finished result waits in the output register under out_stall while the
// next beat is accepted; a later query holds in its last state until then.
module grid_bilinear_bicubic_interpolator_core #(
  parameter int GRID_COLS   = gbbi_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = gbbi_pkg::GRID_ROWS_DEF,
  parameter int SAMPLE_BITS = gbbi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         mode,
  input  logic [7:0]                         write_col,
  input  logic [7:0]                         write_row,
  input  logic signed [15:0]                 write_value,
  input  logic signed [gbbi_pkg::LAT_W-1:0]  query_lat,
  input  logic signed [gbbi_pkg::LON_W-1:0]  query_lon,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gbbi_pkg::ELEV_W-1:0] elevation,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gbbi_pkg::ADDR_W-1:0]        paddr,
  input  logic [gbbi_pkg::DATA_W-1:0]        pwdata,
  output logic [gbbi_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import gbbi_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  gbbi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gbbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  gbbi_dpath #(
    .GRID_COLS   (GRID_COLS),
    .GRID_ROWS   (GRID_ROWS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .write_col   (write_col),
    .write_row   (write_row),
    .write_value (write_value),
    .query_lat   (query_lat),
    .query_lon   (query_lon),
    .elevation   (elevation)
  );

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> !cmd.wr)
    else $error("grid write and read in the same cycle");

  a_busy_after_query: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> in_stall)
    else $error("query accepted but block not busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

endmodule
